>>> src/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types for the rgb / hsv / hsl colour converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

    // conversion selected by the mode register
    typedef enum logic [1:0] {
        MODE_RGB_HSV = 2'd0,
        MODE_HSV_RGB = 2'd1,
        MODE_RGB_HSL = 2'd2,
        MODE_HSL_RGB = 2'd3
    } t_mode;

    // number of lanes through the divider
    localparam int LANES = 3;

endpackage

>>> src/rgb_hsv_hsl_convert_unit.sv
// ----------------------------------------------------------------------------
// rgb_hsv_hsl_convert_unit
// Per-pixel converter between rgb and hsv / hsl, selected by a mode register.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one pixel per clock while neither side
// stalls. A request passes through six front stages, one restoring divider
// stage per quotient bit, then a rounding stage and the output register. The
// divider sets the latency. Write the mode only while no request is in
// flight.
module rgb_hsv_hsl_convert_unit #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [COMPONENT_BITS-1:0] i_first_in,
    input  logic [COMPONENT_BITS-1:0] i_second_in,
    input  logic [COMPONENT_BITS-1:0] i_third_in,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [COMPONENT_BITS-1:0] o_first_out,
    output logic [COMPONENT_BITS-1:0] o_second_out,
    output logic [COMPONENT_BITS-1:0] o_third_out,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_data
);

    localparam int W      = COMPONENT_BITS;
    localparam int NL     = rhc_pkg::LANES;
    localparam int SIDE_W = 2 * W + 6;

    rhc_pkg::t_mode          r_mode;
    logic                    prep_ready;
    logic                    prep_valid;
    logic [NL-1:0][3*W-1:0]  prep_dvd;
    logic [NL-1:0][2*W:0]    prep_dvs;
    logic [SIDE_W-1:0]       prep_side;
    logic                    div_ready;
    logic                    div_valid;
    logic [NL-1:0][W-1:0]    div_quo;
    logic [NL-1:0][2*W:0]    div_rem;
    logic [NL-1:0][2*W:0]    div_dvs;
    logic [SIDE_W-1:0]       div_side;
    logic                    out_ready;

    // mode register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= rhc_pkg::MODE_RGB_HSV;
        end else if (i_cfg_valid) begin
            r_mode <= rhc_pkg::t_mode'(i_cfg_data);
        end
    end

    assign o_stall = !prep_ready;

    // operand preparation
    rhc_prep #(.COMPONENT_BITS(W)) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (prep_ready),
        .i_mode   (r_mode),
        .i_first  (i_first_in),
        .i_second (i_second_in),
        .i_third  (i_third_in),
        .o_valid  (prep_valid),
        .i_ready  (div_ready),
        .o_dvd    (prep_dvd),
        .o_dvs    (prep_dvs),
        .o_side   (prep_side)
    );

    // divider
    rhc_div #(.COMPONENT_BITS(W), .SIDE_W(SIDE_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep_valid),
        .o_ready (div_ready),
        .i_dvd   (prep_dvd),
        .i_dvs   (prep_dvs),
        .i_side  (prep_side),
        .o_valid (div_valid),
        .i_ready (out_ready),
        .o_quo   (div_quo),
        .o_rem   (div_rem),
        .o_dvs   (div_dvs),
        .o_side  (div_side)
    );

    // rounding and output register
    rhc_out #(.COMPONENT_BITS(W)) u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (div_valid),
        .o_ready  (out_ready),
        .i_quo    (div_quo),
        .i_rem    (div_rem),
        .i_dvs    (div_dvs),
        .i_side   (div_side),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_first  (o_first_out),
        .o_second (o_second_out),
        .o_third  (o_third_out)
    );

endmodule

>>> src/rhc_prep.sv
// ----------------------------------------------------------------------------
// rhc_prep
// Front pipeline: forms a dividend and divisor for each of the three lanes
// and the sideband needed to finish each request.
// ----------------------------------------------------------------------------
module rhc_prep #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  rhc_pkg::t_mode                            i_mode,
    input  logic [COMPONENT_BITS-1:0]                 i_first,
    input  logic [COMPONENT_BITS-1:0]                 i_second,
    input  logic [COMPONENT_BITS-1:0]                 i_third,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic [rhc_pkg::LANES-1:0][3*COMPONENT_BITS-1:0] o_dvd,
    output logic [rhc_pkg::LANES-1:0][2*COMPONENT_BITS:0]   o_dvs,
    output logic [2*COMPONENT_BITS+5:0]               o_side
);

    localparam int W   = COMPONENT_BITS;
    localparam int NST = 6;
    localparam int NL  = rhc_pkg::LANES;

    localparam logic [W-1:0]        MAXV = {W{1'b1}};
    localparam logic [2*W-1:0]      SQ   = {{W{1'b0}}, MAXV} * {{W{1'b0}}, MAXV};
    localparam logic signed [W+3:0] MXS  = {4'b0000, MAXV};
    localparam logic signed [W+3:0] MX2  = MXS <<< 1;
    localparam logic signed [W+3:0] MX3  = MXS + MX2;
    localparam logic signed [W+3:0] MX4  = MXS <<< 2;

    // which channel holds the maximum, and how the hue numerator is formed
    typedef enum logic [1:0] {
        HUE_RED_UP   = 2'd0,
        HUE_RED_WRAP = 2'd1,
        HUE_BLUE     = 2'd2,
        HUE_GREEN    = 2'd3
    } t_hue_sel;

    typedef struct packed {
        rhc_pkg::t_mode                mode;
        logic [W-1:0]                  x;
        logic [W-1:0]                  s;
        logic [W-1:0]                  hi;
        logic [W-1:0]                  lo;
        t_hue_sel                      sel;
        logic signed [W:0]             diff;
        logic [W+2:0]                  h6;
        logic [W-1:0]                  c;
        logic [W:0]                    sum;
        logic [NL-1:0][W-1:0]          f;
        logic [W-1:0]                  dl;
        logic [W+2:0]                  num_h;
        logic [W+2:0]                  den_h;
        logic [W-1:0]                  den_s;
        logic [W-1:0]                  thr;
        logic                          zero;
        logic [NL-1:0]                 neg;
        logic [NL-1:0][2*W-1:0]        u;
        logic [NL-1:0][W-1:0]          a;
        logic [NL-1:0][2*W-1:0]        pp_hi;
        logic [NL-1:0][2*W-1:0]        pp_lo;
        logic [NL-1:0][3*W-1:0]        dvd;
        logic [NL-1:0][2*W:0]          dvs;
    } t_stage;

    t_stage           r_st [NST];
    t_stage           n_st [NST];
    logic [NST-1:0]   r_v;
    logic [NST:0]     ld;

    function automatic logic signed [W+3:0] abs_s(input logic signed [W+3:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [W-1:0] clamp_u(input logic signed [W+3:0] v);
        logic [W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > MXS) begin
            res = MAXV;
        end else begin
            res = v[W-1:0];
        end
        return res;
    endfunction

    // a stage loads when it is empty or its contents move on
    always_comb begin
        ld[NST] = i_ready;
        for (int j = NST - 1; j >= 0; j--) begin
            ld[j] = !r_v[j] || ld[j+1];
        end
    end

    assign o_ready = ld[0];
    assign o_valid = r_v[NST-1];

    // next values of all stages
    always_comb begin
        logic                  r_max;
        logic signed [W+3:0]   h6s;
        logic signed [W+3:0]   tmp;
        logic signed [W+3:0]   e;
        logic signed [W+3:0]   nsum;
        logic [W+2:0]          kc;
        logic [W+1:0]          half;
        logic [W-1:0]          mop;
        logic                  hsv_inv;
        logic                  hsl_inv;
        logic                  fwd;

        // stage 1: sort the rgb channels, scale the hue by six
        n_st[0]      = '0;
        n_st[0].mode = i_mode;
        n_st[0].x    = i_third;
        n_st[0].s    = i_second;
        r_max = (i_first >= i_second) && (i_first >= i_third);
        n_st[0].hi = r_max ? i_first : ((i_second > i_third) ? i_second : i_third);
        n_st[0].lo = (i_first <= i_second && i_first <= i_third) ? i_first :
                     ((i_second < i_third) ? i_second : i_third);
        if (r_max) begin
            n_st[0].sel  = (i_second >= i_third) ? HUE_RED_UP : HUE_RED_WRAP;
            n_st[0].diff = $signed({1'b0, i_second}) - $signed({1'b0, i_third});
        end else if (i_third > i_second) begin
            n_st[0].sel  = HUE_BLUE;
            n_st[0].diff = $signed({1'b0, i_first}) - $signed({1'b0, i_second});
        end else begin
            n_st[0].sel  = HUE_GREEN;
            n_st[0].diff = $signed({1'b0, i_third}) - $signed({1'b0, i_first});
        end
        n_st[0].h6 = {1'b0, i_first, 2'b00} + {2'b00, i_first, 1'b0};

        // stage 2: chroma, sum, hue weights, lightness span
        n_st[1]     = r_st[0];
        n_st[1].c   = r_st[0].hi - r_st[0].lo;
        n_st[1].sum = {1'b0, r_st[0].hi} + {1'b0, r_st[0].lo};
        h6s = $signed({1'b0, r_st[0].h6});
        n_st[1].f[0] = clamp_u(abs_s(h6s - MX3) - MXS);
        n_st[1].f[1] = clamp_u(MX2 - abs_s(h6s - MX2));
        n_st[1].f[2] = clamp_u(MX2 - abs_s(h6s - MX4));
        tmp = $signed({3'b000, r_st[0].x, 1'b0}) - MXS;
        tmp = MXS - abs_s(tmp);
        n_st[1].dl = tmp[W-1:0];

        // stage 3: hue numerator and divisors; first product of the inverse
        n_st[2] = r_st[1];
        case (r_st[1].sel)
            HUE_RED_UP:   kc = '0;
            HUE_RED_WRAP: kc = {1'b0, r_st[1].c, 2'b00} + {2'b00, r_st[1].c, 1'b0};
            HUE_BLUE:     kc = {1'b0, r_st[1].c, 2'b00};
            HUE_GREEN:    kc = {2'b00, r_st[1].c, 1'b0};
            default:      kc = '0;
        endcase
        nsum = $signed({1'b0, kc}) + $signed({{3{r_st[1].diff[W]}}, r_st[1].diff});
        n_st[2].num_h = nsum[W+2:0];
        n_st[2].den_h = {1'b0, r_st[1].c, 2'b00} + {2'b00, r_st[1].c, 1'b0};
        n_st[2].zero  = (r_st[1].c == '0);
        half = {1'b0, r_st[1].sum} + {{(W+1){1'b0}}, 1'b1};
        if (r_st[1].mode == rhc_pkg::MODE_RGB_HSL) begin
            if (r_st[1].sum <= {1'b0, MAXV}) begin
                n_st[2].den_s = r_st[1].sum[W-1:0];
            end else begin
                n_st[2].den_s = MAXV - (r_st[1].sum[W-1:0] - MAXV);
            end
            n_st[2].thr = half[W:1];
        end else begin
            n_st[2].den_s = r_st[1].hi;
            n_st[2].thr   = r_st[1].hi;
        end
        hsv_inv = (r_st[1].mode == rhc_pkg::MODE_HSV_RGB);
        hsl_inv = (r_st[1].mode == rhc_pkg::MODE_HSL_RGB);
        for (int k = 0; k < NL; k++) begin
            mop = hsv_inv ? (MAXV - r_st[1].f[k]) : r_st[1].dl;
            n_st[2].u[k] = {{W{1'b0}}, r_st[1].s} * {{W{1'b0}}, mop};
            e = $signed({3'b000, r_st[1].f[k], 1'b0}) - MXS;
            // only the hsl inverse subtracts, so only it rounds ties down
            n_st[2].neg[k] = (e < 0) && hsl_inv;
            e = abs_s(e);
            n_st[2].a[k] = e[W-1:0];
        end

        // stage 4: second operand pair per lane
        n_st[3] = r_st[2];
        hsv_inv = (r_st[2].mode == rhc_pkg::MODE_HSV_RGB);
        for (int k = 0; k < NL; k++) begin
            if (hsv_inv) begin
                n_st[3].u[k] = SQ - r_st[2].u[k];
                n_st[3].a[k] = r_st[2].x;
            end
        end

        // stage 5: partial products, split at the component width
        n_st[4] = r_st[3];
        for (int k = 0; k < NL; k++) begin
            n_st[4].pp_hi[k] = {{W{1'b0}}, r_st[3].a[k]} *
                               {{W{1'b0}}, r_st[3].u[k][2*W-1:W]};
            n_st[4].pp_lo[k] = {{W{1'b0}}, r_st[3].a[k]} *
                               {{W{1'b0}}, r_st[3].u[k][W-1:0]};
        end

        // stage 6: dividend and divisor per lane
        n_st[5] = r_st[4];
        fwd = (r_st[4].mode == rhc_pkg::MODE_RGB_HSV) ||
              (r_st[4].mode == rhc_pkg::MODE_RGB_HSL);
        for (int k = 0; k < NL; k++) begin
            n_st[5].dvd[k] = (3*W)'({r_st[4].pp_hi[k], {W{1'b0}}}) +
                             (3*W)'(r_st[4].pp_lo[k]);
            n_st[5].dvs[k] = (r_st[4].mode == rhc_pkg::MODE_HSV_RGB) ?
                             (2*W+1)'(SQ) : {SQ, 1'b0};
        end
        if (fwd) begin
            n_st[5].dvd[0] = (3*W)'({r_st[4].num_h, {W{1'b0}}}) - (3*W)'(r_st[4].num_h);
            n_st[5].dvs[0] = (2*W+1)'(r_st[4].den_h);
            n_st[5].dvd[1] = (3*W)'({r_st[4].c, {W{1'b0}}}) - (3*W)'(r_st[4].c);
            n_st[5].dvs[1] = (2*W+1)'(r_st[4].den_s);
            n_st[5].dvd[2] = '0;
            n_st[5].dvs[2] = (2*W+1)'(1);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int j = 0; j < NST; j++) begin
                if (ld[j]) begin
                    r_v[j] <= (j == 0) ? i_valid : r_v[(j == 0) ? 0 : j - 1];
                end
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NST; j++) begin
            if (ld[j]) begin
                r_st[j] <= n_st[j];
            end
        end
    end

    assign o_dvd  = r_st[NST-1].dvd;
    assign o_dvs  = r_st[NST-1].dvs;
    assign o_side = {r_st[NST-1].mode, r_st[NST-1].zero, r_st[NST-1].neg,
                     r_st[NST-1].x, r_st[NST-1].thr};

endmodule

>>> src/rhc_div.sv
// ----------------------------------------------------------------------------
// rhc_div
// Pipelined restoring divider, three lanes, one quotient bit per stage,
// with a sideband that travels alongside.
// ----------------------------------------------------------------------------
module rhc_div #(
    parameter int COMPONENT_BITS = 16,
    parameter int SIDE_W         = 38
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_valid,
    output logic                                            o_ready,
    input  logic [rhc_pkg::LANES-1:0][3*COMPONENT_BITS-1:0] i_dvd,
    input  logic [rhc_pkg::LANES-1:0][2*COMPONENT_BITS:0]   i_dvs,
    input  logic [SIDE_W-1:0]                               i_side,
    output logic                                            o_valid,
    input  logic                                            i_ready,
    output logic [rhc_pkg::LANES-1:0][COMPONENT_BITS-1:0]   o_quo,
    output logic [rhc_pkg::LANES-1:0][2*COMPONENT_BITS:0]   o_rem,
    output logic [rhc_pkg::LANES-1:0][2*COMPONENT_BITS:0]   o_dvs,
    output logic [SIDE_W-1:0]                               o_side
);

    localparam int W  = COMPONENT_BITS;
    localparam int NL = rhc_pkg::LANES;

    logic [NL-1:0][3*W-1:0] r_rem  [W];
    logic [NL-1:0][2*W:0]   r_den  [W];
    logic [NL-1:0][W-1:0]   r_q    [W];
    logic [SIDE_W-1:0]      r_side [W];
    logic [W-1:0]           r_v;

    logic [NL-1:0][3*W-1:0] n_rem  [W];
    logic [NL-1:0][2*W:0]   n_den  [W];
    logic [NL-1:0][W-1:0]   n_q    [W];
    logic [SIDE_W-1:0]      n_side [W];
    logic [W:0]             ld;

    // load chain from the output side back
    always_comb begin
        ld[W] = i_ready;
        for (int j = W - 1; j >= 0; j--) begin
            ld[j] = !r_v[j] || ld[j+1];
        end
    end

    assign o_ready = ld[0];
    assign o_valid = r_v[W-1];

    // one compare and subtract per lane and stage
    always_comb begin
        logic [NL-1:0][3*W-1:0] src_rem;
        logic [NL-1:0][2*W:0]   src_den;
        logic [NL-1:0][W-1:0]   src_q;
        logic [3*W-1:0]         dsh;
        logic                   ge;
        for (int j = 0; j < W; j++) begin
            if (j == 0) begin
                src_rem   = i_dvd;
                src_den   = i_dvs;
                src_q     = '0;
                n_side[j] = i_side;
            end else begin
                src_rem   = r_rem[(j == 0) ? 0 : j - 1];
                src_den   = r_den[(j == 0) ? 0 : j - 1];
                src_q     = r_q[(j == 0) ? 0 : j - 1];
                n_side[j] = r_side[(j == 0) ? 0 : j - 1];
            end
            for (int k = 0; k < NL; k++) begin
                dsh = (3*W)'(src_den[k]) << (W - 1 - j);
                ge  = (src_rem[k] >= dsh);
                n_rem[j][k] = ge ? (src_rem[k] - dsh) : src_rem[k];
                n_q[j][k]   = {src_q[k][W-2:0], ge};
            end
            n_den[j] = src_den;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int j = 0; j < W; j++) begin
                if (ld[j]) begin
                    r_v[j] <= (j == 0) ? i_valid : r_v[(j == 0) ? 0 : j - 1];
                end
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < W; j++) begin
            if (ld[j]) begin
                r_rem[j]  <= n_rem[j];
                r_den[j]  <= n_den[j];
                r_q[j]    <= n_q[j];
                r_side[j] <= n_side[j];
            end
        end
    end

    // remainder is below the divisor, so its low bits hold it
    always_comb begin
        for (int k = 0; k < NL; k++) begin
            o_rem[k] = r_rem[W-1][k][2*W:0];
        end
    end

    assign o_quo  = r_q[W-1];
    assign o_dvs  = r_den[W-1];
    assign o_side = r_side[W-1];

endmodule

>>> src/rhc_out.sv
// ----------------------------------------------------------------------------
// rhc_out
// Rounding, saturation and result selection, ending in the output register.
// ----------------------------------------------------------------------------
module rhc_out #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_valid,
    output logic                                          o_ready,
    input  logic [rhc_pkg::LANES-1:0][COMPONENT_BITS-1:0] i_quo,
    input  logic [rhc_pkg::LANES-1:0][2*COMPONENT_BITS:0] i_rem,
    input  logic [rhc_pkg::LANES-1:0][2*COMPONENT_BITS:0] i_dvs,
    input  logic [2*COMPONENT_BITS+5:0]                   i_side,
    output logic                                          o_valid,
    input  logic                                          i_stall,
    output logic [COMPONENT_BITS-1:0]                     o_first,
    output logic [COMPONENT_BITS-1:0]                     o_second,
    output logic [COMPONENT_BITS-1:0]                     o_third
);

    localparam int W  = COMPONENT_BITS;
    localparam int NL = rhc_pkg::LANES;
    localparam logic [W-1:0] MAXV = {W{1'b1}};

    logic [NL-1:0][W:0]   r_rq;
    logic [NL-1:0][W:0]   n_rq;
    logic [2*W+5:0]       r_side;
    logic                 r_va;
    logic [NL-1:0][W-1:0] r_res;
    logic [NL-1:0][W-1:0] n_res;
    logic                 r_vb;
    logic                 ld_a;
    logic                 ld_b;

    assign ld_b    = !r_vb || !i_stall;
    assign ld_a    = !r_va || ld_b;
    assign o_ready = ld_a;
    assign o_valid = r_vb;

    // round to nearest: up when twice the remainder reaches the divisor, or exceeds it on a lane that subtracts
    always_comb begin
        logic up;
        for (int k = 0; k < NL; k++) begin
            if (i_side[2*W+k]) begin
                up = ({i_rem[k], 1'b0} > {1'b0, i_dvs[k]});
            end else begin
                up = ({i_rem[k], 1'b0} >= {1'b0, i_dvs[k]});
            end
            n_rq[k] = {1'b0, i_quo[k]} + {{W{1'b0}}, up};
        end
    end

    // saturate and pick the result per conversion
    always_comb begin
        rhc_pkg::t_mode     mode;
        logic               zero;
        logic [W-1:0]       xv;
        logic [W-1:0]       thr;
        logic [W-1:0]       satq;
        logic [W-1:0]       satv;
        logic signed [W+1:0] v;
        mode = rhc_pkg::t_mode'(r_side[2*W+5:2*W+4]);
        zero = r_side[2*W+3];
        xv   = r_side[2*W-1:W];
        thr  = r_side[W-1:0];
        for (int k = 0; k < NL; k++) begin
            satq = r_rq[k][W] ? MAXV : r_rq[k][W-1:0];
            if (r_side[2*W+k]) begin
                v = $signed({2'b00, xv}) - $signed({1'b0, r_rq[k]});
            end else begin
                v = $signed({2'b00, xv}) + $signed({1'b0, r_rq[k]});
            end
            if (v < 0) begin
                satv = '0;
            end else if (v > $signed({2'b00, MAXV})) begin
                satv = MAXV;
            end else begin
                satv = v[W-1:0];
            end
            case (mode)
                rhc_pkg::MODE_RGB_HSV,
                rhc_pkg::MODE_RGB_HSL: begin
                    if (k == NL - 1) begin
                        n_res[k] = thr;
                    end else begin
                        n_res[k] = zero ? '0 : satq;
                    end
                end
                rhc_pkg::MODE_HSV_RGB: n_res[k] = satq;
                rhc_pkg::MODE_HSL_RGB: n_res[k] = satv;
                default:               n_res[k] = satq;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (ld_a) begin
                r_va <= i_valid;
            end
            if (ld_b) begin
                r_vb <= r_va;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (ld_a) begin
            r_rq   <= n_rq;
            r_side <= i_side;
        end
        if (ld_b) begin
            r_res <= n_res;
        end
    end

    assign o_first  = r_res[0];
    assign o_second = r_res[1];
    assign o_third  = r_res[2];

endmodule

>>> src/rhc_checker.sv
// ----------------------------------------------------------------------------
// rhc_checker
// Port-level checks for the colour converter, bound to the top level.
// ----------------------------------------------------------------------------
module rhc_checker #(
    parameter int COMPONENT_BITS = 16
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [COMPONENT_BITS-1:0] o_first_out,
    input logic [COMPONENT_BITS-1:0] o_second_out,
    input logic [COMPONENT_BITS-1:0] o_third_out
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // input backpressure only when the pipeline is full behind a stalled result
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output can move");

    // a stalled result stays
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("stalled result dropped");

    // a stalled result keeps its value
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_first_out) && $stable(o_second_out) &&
                                  $stable(o_third_out)))
        else $error("stalled result changed");

endmodule

bind rgb_hsv_hsl_convert_unit rhc_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_rhc_checker (.*);

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rgb / hsv / hsl converter: directed extremes and
// special cases in every mode, then random pixels under varied stall patterns,
// each result compared with an exact integer prediction.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CB      = 16;
    localparam longint MAXC = (64'd1 << CB) - 1;
    localparam int  LATENCY = CB + 8;

    typedef struct packed {
        logic [CB-1:0] c0;
        logic [CB-1:0] c1;
        logic [CB-1:0] c2;
    } t_pixel;

    // ------------------------------------------------------------------------
    // exact pixel predictor and pending result store
    // ------------------------------------------------------------------------
    class pixel_scoreboard;
        rhc_pkg::t_mode mode;
        t_pixel         pending_q[$];
        int             errors;

        function new();
            mode = rhc_pkg::MODE_RGB_HSV;
            errors = 0;
        endfunction

        // round(num * MAXC / den) capped at MAXC, zero for zero den
        function longint ratio(longint num, longint den);
            longint q;
            if (den == 0) return 0;
            q = (2 * num * MAXC + den) / (2 * den);
            return (q > MAXC) ? MAXC : q;
        endfunction

        function longint sat(longint v);
            return (v < 0) ? 0 : ((v > MAXC) ? MAXC : v);
        endfunction

        function longint absv(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function t_pixel to_hue(longint r, longint g, longint b, bit hsl);
            longint hi, lo, c, n, sum, den;
            t_pixel p;
            hi = r; lo = r;
            if (g > hi) hi = g;
            if (b > hi) hi = b;
            if (g < lo) lo = g;
            if (b < lo) lo = b;
            c = hi - lo;
            if (r >= g && r >= b) n = (g >= b) ? (g - b) : (6 * c - (b - g));
            else if (b > g)       n = 4 * c + r - g;
            else                  n = 2 * c + b - r;
            p.c0 = (c == 0) ? '0 : CB'(ratio(n, 6 * c));
            if (!hsl) begin
                p.c1 = (c == 0) ? '0 : CB'(ratio(c, hi));
                p.c2 = CB'(hi);
            end else begin
                sum = hi + lo;
                den = (sum <= MAXC) ? sum : (2 * MAXC - sum);
                p.c1 = (c == 0) ? '0 : CB'(ratio(c, den));
                p.c2 = CB'(sat((sum + 1) >> 1));
            end
            return p;
        endfunction

        function t_pixel to_rgb(longint h, longint s, longint x, bit hsl);
            longint w[3];
            longint sq, t, e, dl, pr, v;
            logic [CB-1:0] ch[3];
            sq = MAXC * MAXC;
            w[0] = sat(absv(6 * h - 3 * MAXC) - MAXC);
            w[1] = sat(2 * MAXC - absv(6 * h - 2 * MAXC));
            w[2] = sat(2 * MAXC - absv(6 * h - 4 * MAXC));
            for (int k = 0; k < 3; k++) begin
                if (!hsl) begin
                    t = sq - s * (MAXC - w[k]);
                    ch[k] = CB'(sat((2 * x * t + sq) / (2 * sq)));
                end else begin
                    e = 2 * w[k] - MAXC;
                    dl = MAXC - absv(2 * x - MAXC);
                    pr = dl * s;
                    if (e >= 0) v = x + (absv(e) * pr + sq) / (2 * sq);
                    else        v = x - (absv(e) * pr + sq - 1) / (2 * sq);
                    ch[k] = CB'(sat(v));
                end
            end
            return '{ch[0], ch[1], ch[2]};
        endfunction

        // note an accepted request
        function void note_request(t_pixel px);
            case (mode)
                rhc_pkg::MODE_RGB_HSV: pending_q.push_back(to_hue(px.c0, px.c1, px.c2, 0));
                rhc_pkg::MODE_HSV_RGB: pending_q.push_back(to_rgb(px.c0, px.c1, px.c2, 0));
                rhc_pkg::MODE_RGB_HSL: pending_q.push_back(to_hue(px.c0, px.c1, px.c2, 1));
                default:               pending_q.push_back(to_rgb(px.c0, px.c1, px.c2, 1));
            endcase
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d (mode %s)", what, got, want,
                     mode.name());
            errors++;
        endtask

        // compare a result with the oldest expectation
        task check_result(t_pixel px);
            t_pixel want;
            if (pending_q.size() == 0) begin
                report("unexpected result", 1, 0);
                return;
            end
            want = pending_q.pop_front();
            if (px.c0 !== want.c0) report("first_out", px.c0, want.c0);
            if (px.c1 !== want.c1) report("second_out", px.c1, want.c1);
            if (px.c2 !== want.c2) report("third_out", px.c2, want.c2);
        endtask
    endclass

    logic          i_clk = 0;
    logic          i_rst_n = 0;
    logic          i_valid = 0;
    logic          o_stall;
    logic [CB-1:0] i_first_in = 0, i_second_in = 0, i_third_in = 0;
    logic          o_valid;
    logic          i_stall = 0;
    logic [CB-1:0] o_first_out, o_second_out, o_third_out;
    logic          i_cfg_valid = 0;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_data = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    rhc_pkg::t_mode modes[4];

    pixel_scoreboard sb = new();

    rgb_hsv_hsl_convert_unit #(.COMPONENT_BITS(CB)) dut (.*);

    always #5 i_clk = ~i_clk;

    // receiver: random stall, long hold-off on demand, result checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result('{o_first_out, o_second_out, o_third_out});
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_pixel(t_pixel px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_first_in <= px.c0;
        i_second_in <= px.c1;
        i_third_in <= px.c2;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(px);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_mode(rhc_pkg::t_mode m);
        i_cfg_valid <= 1;
        i_cfg_data <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        sb.mode = m;
    endtask

    function automatic logic [CB-1:0] rand_comp();
        case ($urandom_range(5))
            0: return '0;
            1: return CB'(MAXC);
            2: return CB'($urandom_range(3));
            3: return CB'(MAXC - $urandom_range(3));
            default: return CB'($urandom);
        endcase
    endfunction

    // well-formed pixels with shared or near-equal components for edge cases
    function automatic t_pixel rand_pixel();
        t_pixel p;
        p = '{rand_comp(), rand_comp(), rand_comp()};
        if ($urandom_range(7) == 0) p.c1 = p.c0;
        if ($urandom_range(7) == 0) p.c2 = CB'(p.c0 + $urandom_range(2));
        return p;
    endfunction

    initial begin
        modes = '{rhc_pkg::MODE_RGB_HSV, rhc_pkg::MODE_HSV_RGB,
                  rhc_pkg::MODE_RGB_HSL, rhc_pkg::MODE_HSL_RGB};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed extremes per mode
        foreach (modes[m]) begin
            write_mode(modes[m]);
            send_pixel('{16'd0, 16'd0, 16'd0});
            send_pixel('{16'hffff, 16'hffff, 16'hffff});
            send_pixel('{16'hffff, 16'd0, 16'd0});
            send_pixel('{16'd0, 16'hffff, 16'd0});
            send_pixel('{16'd0, 16'd0, 16'hffff});
            send_pixel('{16'hffff, 16'hffff, 16'h8000});
            send_pixel('{16'hfffe, 16'hffff, 16'h7fff});
            send_pixel('{16'h5555, 16'haaaa, 16'h1234});
            drain();
        end

        // random phases with varied idling and modes, extremes included
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            write_mode(modes[(ph + ph / 4) % 4]);
            if (ph == 4) hold_cycles = 300;
            for (int n = 0; n < 110; n++) begin
                send_pixel(rand_pixel());
                if (ph == 8 && n == 50) begin
                    i_valid <= 0;
                    while (sb.pending_q.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end
endmodule

>>> sim.f
src/rhc_pkg.sv
src/rhc_prep.sv
src/rhc_div.sv
src/rhc_out.sv
src/rgb_hsv_hsl_convert_unit.sv
src/rhc_checker.sv
tb/sv/testbench.sv
